// ----- hw/rtl/msp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked signature patcher package
// Signature table, rewrite instruction words and shared types.
// ----------------------------------------------------------------------------
package msp_pkg;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  kind_t;

  localparam int MAX_SIG = 8;
  localparam int N_SIGS  = 14;
  localparam int FILL_W  = $clog2(MAX_SIG + 1);
  localparam int SEL_W   = $clog2(MAX_SIG);

  typedef logic [FILL_W-1:0] len_t;
  typedef logic [3:0]        tgt_t;

  localparam kind_t KIND_JUMP      = 2'd0;
  localparam kind_t KIND_PUSH_JUMP = 2'd1;
  localparam kind_t KIND_NOP       = 2'd2;

  localparam word_t INSN_LDR_PC  = 32'he51ff004;
  localparam word_t INSN_PUSH_LR = 32'he92d8000;
  localparam word_t INSN_NOP     = 32'he1a00000;

  // Top nibble the previous word must carry before a nop rewrite applies
  localparam logic [3:0] NOP_PREV_COND = 4'he;

  localparam word_t M_ALL = 32'hffffffff;
  localparam word_t M_OP  = 32'hff000000;

  localparam word_t SIG_WORD [N_SIGS][MAX_SIG] = '{
    '{32'he59cc000, 32'he33c0000, 32'h1a000003, 32'hef900005, '0, '0, '0, '0},
    '{32'hef900005, 32'he1a0f00e, '0, '0, '0, '0, '0, '0},
    '{32'he92d000f, 32'he1a0000d, 32'hef90005a, 32'he28dd010, '0, '0, '0, '0},
    '{32'he52d5004, 32'he59d5008, 32'he52d4004, 32'he59d4008,
      32'he1b0ca05, 32'h1a000006, 32'he1a05625, 32'hef9000c0},
    '{32'hef90005b, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'he59fc080, 32'he59cc000, 32'he33c0000, 32'h1a000003, 32'hef900003,
      '0, '0, '0},
    '{32'hef900003, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'hef900003, 32'he3700a01, 32'he1a04000, '0, '0, '0, '0, '0},
    '{32'hef900036, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'hef900036, 32'he3700a01, 32'he1a04000, '0, '0, '0, '0, '0},
    '{32'he59f300c, 32'he3530000, 32'h0a000000, 32'hea000000, 32'hea000000,
      '0, '0, '0},
    '{32'hef90000c, 32'he3700a01, 32'h312fff1e, 32'hea0004bb, '0, '0, '0, '0},
    '{32'hee073f5e, '0, '0, '0, '0, '0, '0, '0},
    '{32'hee070f17, '0, '0, '0, '0, '0, '0, '0}
  };

  localparam word_t SIG_CARE [N_SIGS][MAX_SIG] = '{
    '{M_ALL, M_ALL, M_ALL, M_ALL, '0, '0, '0, '0},
    '{M_ALL, M_ALL, '0, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, M_ALL, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, M_ALL, M_ALL, M_ALL, M_ALL, M_ALL},
    '{M_ALL, M_ALL, M_ALL, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, M_ALL, M_ALL, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, '0, '0, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, M_OP, M_OP, '0, '0, '0},
    '{M_ALL, M_ALL, M_ALL, M_OP, '0, '0, '0, '0},
    '{M_ALL, '0, '0, '0, '0, '0, '0, '0},
    '{M_ALL, '0, '0, '0, '0, '0, '0, '0}
  };

  localparam len_t SIG_LEN [N_SIGS] = '{
    len_t'(4), len_t'(2), len_t'(4), len_t'(8), len_t'(3), len_t'(5), len_t'(3),
    len_t'(3), len_t'(3), len_t'(3), len_t'(5), len_t'(4), len_t'(1), len_t'(1)
  };

  localparam kind_t SIG_KIND [N_SIGS] = '{
    KIND_JUMP, KIND_JUMP, KIND_JUMP, KIND_JUMP, KIND_JUMP, KIND_JUMP, KIND_JUMP,
    KIND_PUSH_JUMP, KIND_JUMP, KIND_PUSH_JUMP, KIND_JUMP, KIND_JUMP,
    KIND_NOP, KIND_NOP
  };

  localparam tgt_t SIG_TGT [N_SIGS] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd0, 4'd0
  };

endpackage

// ----- hw/rtl/masked_signature_patcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked signature patcher
// Scans a code segment for fixed masked signatures and rewrites matches.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled. A request with cmd = 1 loads a
// jump target; with cmd = 0 it adds a code word to an eight-word lookahead
// window. When the window is full, or at a segment end, all fourteen
// signatures are compared in parallel against the window head and one
// decision (a single word or a whole matched region) moves into a 16-word
// output queue. The output side delivers one word per cycle unless stalled;
// a segment end drains the remaining window at one decision per cycle while
// the queue has room. Input is held during that drain, code words also while
// the queue holds more than eight words. Each request is registered first.
module masked_signature_patcher #(
  parameter int TARGET_COUNT = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  input  msp_pkg::word_t code_word,
  input  logic [3:0]    target_index,
  input  logic          segment_end,
  output logic          out_valid,
  input  logic          out_stall,
  output msp_pkg::word_t patched_word,
  output logic          last_word
);
  import msp_pkg::*;

  localparam int TIDX_W   = $clog2(TARGET_COUNT);
  localparam int OQ_DEPTH = 2 * MAX_SIG;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // input register
  logic       rv;
  logic       r_cmd;
  word_t      r_word;
  logic [3:0] r_idx;
  logic       r_end;

  // lookahead window and scan state
  word_t win [MAX_SIG];
  word_t win_next [MAX_SIG];
  len_t  fill, fill_next;
  logic  flushing, flushing_next;
  word_t prev_word, prev_word_next;
  logic  have_prev, have_prev_next;

  word_t ttab [TARGET_COUNT];

  // output queue
  word_t               oq_word [OQ_DEPTH];
  logic                oq_last [OQ_DEPTH];
  word_t               oq_word_next [OQ_DEPTH];
  logic                oq_last_next [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] ocnt, ocnt_next, cnt_p;

  logic        room, consume, insert, decide, closing, pop, found;
  len_t        fill_w, len_d, m_len;
  kind_t       m_kind;
  tgt_t        m_tgt;
  word_t       wv [MAX_SIG];
  word_t       dword [MAX_SIG];
  logic        dlast [MAX_SIG];
  logic [N_SIGS-1:0] hit;

  assign room     = ocnt <= OQ_CNT_W'(OQ_DEPTH - MAX_SIG);
  assign consume  = rv && !flushing && (r_cmd || room);
  assign in_stall = rv && !consume;
  assign insert   = consume && !r_cmd;
  assign fill_w   = fill + len_t'(insert);
  assign decide   = (flushing && room) ||
                    (insert && (r_end || fill_w == len_t'(MAX_SIG)));
  assign closing  = flushing || (insert && r_end);

  assign pop          = out_valid && !out_stall;
  assign out_valid    = ocnt != '0;
  assign patched_word = oq_word[0];
  assign last_word    = oq_last[0];

  // window as seen after the incoming word lands
  always_comb begin
    for (int s = 0; s < MAX_SIG; s++) begin
      wv[s] = (insert && fill == len_t'(s)) ? r_word : win[s];
    end
  end

  // all signatures in parallel
  always_comb begin
    for (int i = 0; i < N_SIGS; i++) begin
      hit[i] = SIG_LEN[i] <= fill_w;
      for (int s = 0; s < MAX_SIG; s++) begin
        if (len_t'(s) < SIG_LEN[i] && ((wv[s] ^ SIG_WORD[i][s]) & SIG_CARE[i][s]) != '0) begin
          hit[i] = 1'b0;
        end
      end
      if (SIG_KIND[i] == KIND_NOP &&
          !(have_prev && prev_word[31:28] == NOP_PREV_COND)) begin
        hit[i] = 1'b0;
      end
    end
  end

  // earliest table entry wins
  always_comb begin
    found  = 1'b0;
    m_len  = len_t'(1);
    m_kind = KIND_JUMP;
    m_tgt  = '0;
    for (int i = N_SIGS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found  = 1'b1;
        m_len  = SIG_LEN[i];
        m_kind = SIG_KIND[i];
        m_tgt  = SIG_TGT[i];
      end
    end
  end

  assign len_d = found ? m_len : len_t'(1);

  // rewritten region
  always_comb begin
    for (int k = 0; k < MAX_SIG; k++) begin
      dword[k] = wv[k];
      dlast[k] = closing && len_d == fill_w && len_t'(k + 1) == len_d;
    end
    if (found) begin
      unique case (m_kind)
        KIND_JUMP: begin
          dword[0] = INSN_LDR_PC;
          dword[1] = ttab[m_tgt[TIDX_W-1:0]];
        end
        KIND_PUSH_JUMP: begin
          dword[0] = INSN_PUSH_LR;
          dword[1] = INSN_LDR_PC;
          dword[2] = ttab[m_tgt[TIDX_W-1:0]];
        end
        KIND_NOP: begin
          dword[0] = INSN_NOP;
        end
        default: begin
          dword[0] = wv[0];
        end
      endcase
    end
  end

  // window advance and scan state
  always_comb begin
    logic [FILL_W-1:0] src;
    logic [FILL_W-1:0] lm1;
    win_next       = wv;
    fill_next      = fill_w;
    flushing_next  = flushing;
    have_prev_next = have_prev;
    prev_word_next = prev_word;
    src            = '0;
    lm1            = len_d - len_t'(1);
    if (decide) begin
      for (int s = 0; s < MAX_SIG; s++) begin
        src = len_t'(s) + len_d;
        win_next[s] = (src < len_t'(MAX_SIG)) ? wv[src[SEL_W-1:0]] : '0;
      end
      fill_next      = fill_w - len_d;
      flushing_next  = closing && len_d != fill_w;
      have_prev_next = !(closing && len_d == fill_w);
      prev_word_next = dword[lm1[SEL_W-1:0]];
    end
  end

  // output queue: pop at the head, append the decided region at the tail
  always_comb begin
    logic [OQ_CNT_W-1:0] rel;
    rel   = '0;
    cnt_p = ocnt - OQ_CNT_W'(pop);
    for (int j = 0; j < OQ_DEPTH - 1; j++) begin
      oq_word_next[j] = pop ? oq_word[j + 1] : oq_word[j];
      oq_last_next[j] = pop ? oq_last[j + 1] : oq_last[j];
    end
    oq_word_next[OQ_DEPTH-1] = oq_word[OQ_DEPTH-1];
    oq_last_next[OQ_DEPTH-1] = oq_last[OQ_DEPTH-1];
    if (decide) begin
      for (int j = 0; j < OQ_DEPTH; j++) begin
        rel = OQ_CNT_W'(j) - cnt_p;
        if (OQ_CNT_W'(j) >= cnt_p && rel < OQ_CNT_W'(len_d)) begin
          oq_word_next[j] = dword[rel[SEL_W-1:0]];
          oq_last_next[j] = dlast[rel[SEL_W-1:0]];
        end
      end
    end
    ocnt_next = cnt_p + (decide ? OQ_CNT_W'(len_d) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv        <= 1'b0;
      fill      <= '0;
      flushing  <= 1'b0;
      have_prev <= 1'b0;
      ocnt      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        rv <= 1'b1;
      end else if (consume) begin
        rv <= 1'b0;
      end
      fill      <= fill_next;
      flushing  <= flushing_next;
      have_prev <= have_prev_next;
      ocnt      <= ocnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_cmd  <= cmd;
      r_word <= code_word;
      r_idx  <= target_index;
      r_end  <= segment_end;
    end
    // drop loads beyond the table
    if (consume && r_cmd && {1'b0, r_idx} < 5'(TARGET_COUNT)) begin
      ttab[r_idx[TIDX_W-1:0]] <= r_word;
    end
    win       <= win_next;
    prev_word <= prev_word_next;
    oq_word   <= oq_word_next;
    oq_last   <= oq_last_next;
  end

endmodule

// ----- hw/rtl/msp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked signature patcher checker
// Port-level checks on request ordering and word conservation.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          cmd,
  input msp_pkg::word_t code_word,
  input logic [3:0]    target_index,
  input logic          segment_end,
  input logic          out_valid,
  input logic          out_stall,
  input msp_pkg::word_t patched_word,
  input logic          last_word
);
  import msp_pkg::*;

  // input register, window and output queue
  localparam int MAX_INFLIGHT = 1 + MAX_SIG + 2 * MAX_SIG;
  localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

  logic [CNT_W-1:0] inflight;
  logic             code_in, word_out;

  assign code_in  = in_valid && !in_stall && !cmd;
  assign word_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(code_in) - CNT_W'(word_out);
    end
  end

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(patched_word) && $stable(last_word))
    else $error("stalled output changed");

  // stall only rises after a request was taken
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall without a pending request");

  // every output word comes from a streamed code word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("output word with nothing in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(MAX_INFLIGHT))
    else $error("more words in flight than storage");

endmodule

bind masked_signature_patcher msp_checker u_msp_checker (.*);

// ----- test/patch_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patcher testbench package
// Signature table, request type and the scoreboard that predicts the
// rewritten word stream of the masked signature patcher and checks it.
// ----------------------------------------------------------------------------
package patch_tb_pkg;

  typedef msp_pkg::word_t word_t;

  typedef enum logic {CMD_STREAM = 1'b0, CMD_LOAD = 1'b1} cmd_e;
  typedef enum int {REWRITE_JUMP, REWRITE_PUSH_JUMP, REWRITE_NOP} rewrite_e;

  localparam int WINDOW_WORDS = 8;
  localparam int TARGET_SLOTS = 10;
  localparam int N_PATTERNS   = 14;

  localparam word_t LDR_PC_WORD  = 32'he51ff004;
  localparam word_t PUSH_LR_WORD = 32'he92d8000;
  localparam word_t NOP_WORD     = 32'he1a00000;
  localparam word_t FULL         = 32'hffffffff;
  localparam word_t OPC          = 32'hff000000;

  localparam word_t PAT_WORD [N_PATTERNS][WINDOW_WORDS] = '{
    '{32'he59cc000, 32'he33c0000, 32'h1a000003, 32'hef900005, '0, '0, '0, '0},
    '{32'hef900005, 32'he1a0f00e, '0, '0, '0, '0, '0, '0},
    '{32'he92d000f, 32'he1a0000d, 32'hef90005a, 32'he28dd010, '0, '0, '0, '0},
    '{32'he52d5004, 32'he59d5008, 32'he52d4004, 32'he59d4008,
      32'he1b0ca05, 32'h1a000006, 32'he1a05625, 32'hef9000c0},
    '{32'hef90005b, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'he59fc080, 32'he59cc000, 32'he33c0000, 32'h1a000003, 32'hef900003,
      '0, '0, '0},
    '{32'hef900003, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'hef900003, 32'he3700a01, 32'he1a04000, '0, '0, '0, '0, '0},
    '{32'hef900036, 32'he3700a01, 32'h312fff1e, '0, '0, '0, '0, '0},
    '{32'hef900036, 32'he3700a01, 32'he1a04000, '0, '0, '0, '0, '0},
    '{32'he59f300c, 32'he3530000, 32'h0a000000, 32'hea000000, 32'hea000000,
      '0, '0, '0},
    '{32'hef90000c, 32'he3700a01, 32'h312fff1e, 32'hea0004bb, '0, '0, '0, '0},
    '{32'hee073f5e, '0, '0, '0, '0, '0, '0, '0},
    '{32'hee070f17, '0, '0, '0, '0, '0, '0, '0}
  };

  localparam word_t PAT_MASK [N_PATTERNS][WINDOW_WORDS] = '{
    '{FULL, FULL, FULL, FULL, '0, '0, '0, '0},
    '{FULL, FULL, '0, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, FULL, '0, '0, '0, '0},
    '{FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL},
    '{FULL, FULL, FULL, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, FULL, FULL, '0, '0, '0},
    '{FULL, FULL, FULL, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, '0, '0, '0, '0, '0},
    '{FULL, FULL, FULL, OPC, OPC, '0, '0, '0},
    '{FULL, FULL, FULL, OPC, '0, '0, '0, '0},
    '{FULL, '0, '0, '0, '0, '0, '0, '0},
    '{FULL, '0, '0, '0, '0, '0, '0, '0}
  };

  localparam int PAT_LEN [N_PATTERNS] = '{4, 2, 4, 8, 3, 5, 3, 3, 3, 3, 5, 4, 1, 1};

  localparam rewrite_e PAT_KIND [N_PATTERNS] = '{
    REWRITE_JUMP, REWRITE_JUMP, REWRITE_JUMP, REWRITE_JUMP, REWRITE_JUMP,
    REWRITE_JUMP, REWRITE_JUMP, REWRITE_PUSH_JUMP, REWRITE_JUMP,
    REWRITE_PUSH_JUMP, REWRITE_JUMP, REWRITE_JUMP, REWRITE_NOP, REWRITE_NOP
  };

  localparam int PAT_TARGET [N_PATTERNS] = '{0, 0, 1, 2, 3, 4, 4, 5, 6, 7, 8, 9, 0, 0};

  typedef struct {
    cmd_e       cmd;
    word_t      word;
    logic [3:0] slot;
    logic       seg_end;
  } request_t;

  typedef struct {
    word_t word;
    logic  last;
  } patched_t;

  class patch_scoreboard;
    word_t       window [WINDOW_WORDS];
    int          fill;
    word_t       prev_word;
    bit          have_prev;
    word_t       targets [TARGET_SLOTS];
    patched_t    expected_words [$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned segments;
    int unsigned loads;
    int unsigned rewrites [3];

    function new();
      foreach (window[i]) window[i] = '0;
      foreach (targets[i]) targets[i] = '0;
      foreach (rewrites[i]) rewrites[i] = 0;
      fill = 0;
      prev_word = '0;
      have_prev = 1'b0;
      mismatches = 0;
      words_checked = 0;
      segments = 0;
      loads = 0;
    endfunction

    // First pattern that fits the window head, or -1
    function int find_pattern();
      for (int i = 0; i < N_PATTERNS; i++) begin
        bit hit;
        hit = (PAT_LEN[i] <= fill);
        for (int s = 0; s < PAT_LEN[i] && hit; s++)
          if (((window[s] ^ PAT_WORD[i][s]) & PAT_MASK[i][s]) != '0) hit = 1'b0;
        if (hit && PAT_KIND[i] == REWRITE_NOP && !(have_prev && prev_word[31:28] == 4'he))
          hit = 1'b0;
        if (hit) return i;
      end
      return -1;
    endfunction

    // Emit one unmatched word or one rewritten region from the window head
    function void emit_region(bit at_end);
      word_t    region [WINDOW_WORDS];
      patched_t item;
      int       pat;
      int       len;
      pat = find_pattern();
      len = (pat < 0) ? 1 : PAT_LEN[pat];
      for (int k = 0; k < len; k++) region[k] = window[k];
      if (pat >= 0) begin
        rewrites[PAT_KIND[pat]]++;
        case (PAT_KIND[pat])
          REWRITE_JUMP: begin
            region[0] = LDR_PC_WORD;
            region[1] = targets[PAT_TARGET[pat]];
          end
          REWRITE_PUSH_JUMP: begin
            region[0] = PUSH_LR_WORD;
            region[1] = LDR_PC_WORD;
            region[2] = targets[PAT_TARGET[pat]];
          end
          default: region[0] = NOP_WORD;
        endcase
      end
      for (int k = 0; k < len; k++) begin
        item.word = region[k];
        item.last = at_end && (k + 1 == len) && (len == fill);
        expected_words.push_back(item);
        prev_word = region[k];
        have_prev = 1'b1;
      end
      for (int k = 0; k + len < fill; k++) window[k] = window[k + len];
      fill -= len;
    endfunction

    function void note_request(cmd_e cmd, word_t word, logic [3:0] slot, logic seg_end);
      if (cmd == CMD_LOAD) begin
        loads++;
        if (slot < TARGET_SLOTS) targets[slot] = word;
        return;
      end
      if (fill < WINDOW_WORDS) begin
        window[fill] = word;
        fill++;
      end
      if (seg_end) begin
        while (fill > 0) emit_region(1'b1);
        have_prev = 1'b0;
        segments++;
      end else if (fill >= WINDOW_WORDS) begin
        emit_region(1'b0);
      end
    endfunction

    function void report(string what, word_t exp_w, logic exp_l, word_t got_w, logic got_l);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH (%s) at %0t: expected %h last=%b, got %h last=%b",
                 what, $time, exp_w, exp_l, got_w, got_l);
    endfunction

    function void check_word(word_t word, logic last);
      patched_t want;
      if (expected_words.size() == 0) begin
        report("no word pending", '0, 1'b0, word, last);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (want.word !== word || want.last !== last)
        report("wrong word", want.word, want.last, word, last);
    endfunction
  endclass

endpackage

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked signature patcher testbench
// Streams code segments built from whole, partial and corrupted signatures
// plus target table loads, with random input gaps and output stalls, and
// compares every output word against a predicted rewritten stream.
// ----------------------------------------------------------------------------
module tb_top;
  import patch_tb_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_STOP = 350;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_COMB, STALL_HEAVY} stall_mode_e;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  logic           cmd;
  msp_pkg::word_t code_word;
  logic [3:0]     target_index;
  logic           segment_end;
  logic           out_valid;
  logic           out_stall;
  msp_pkg::word_t patched_word;
  logic           last_word;

  patch_scoreboard board;
  request_t        segment_q [$];
  int unsigned     requests_sent;
  int unsigned     burst_left;
  int unsigned     stream_words;
  int unsigned     idle_cycles;
  logic [5:0]      stall_tick;
  stall_mode_e     stall_mode;

  masked_signature_patcher dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .code_word    (code_word),
    .target_index (target_index),
    .segment_end  (segment_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .patched_word (patched_word),
    .last_word    (last_word)
  );

  always #5 clk = ~clk;

  // Drive one request, inserting a random gap at the start of each burst
  task automatic send_request(input cmd_e c, input word_t w, input logic [3:0] slot,
                              input logic se);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    cmd          <= c;
    code_word    <= w;
    target_index <= slot;
    segment_end  <= se;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_request(c, w, slot, se);
    requests_sent++;
  endtask

  // Queue a code word, now and then preceded by a table load
  task automatic queue_word(input word_t w);
    request_t r;
    if ($urandom_range(0, 11) == 0) begin
      r.cmd     = CMD_LOAD;
      r.word    = $urandom;
      r.slot    = 4'($urandom_range(0, 15));
      r.seg_end = 1'($urandom_range(0, 1));
      segment_q.push_back(r);
    end
    r.cmd     = CMD_STREAM;
    r.word    = w;
    r.slot    = 4'($urandom_range(0, 15));
    r.seg_end = 1'b0;
    segment_q.push_back(r);
    stream_words++;
  endtask

  // Queue the first count words of a pattern; don't-care bits are random, and with corrupt set one cared bit is flipped
  task automatic queue_pattern(input int pat, input int count, input bit corrupt);
    word_t w;
    int    bad_word;
    int    bad_bit;
    bad_word = $urandom_range(0, count - 1);
    bad_bit  = $urandom_range(0, 31);
    if (!PAT_MASK[pat][bad_word][bad_bit]) bad_bit = 31;
    for (int k = 0; k < count; k++) begin
      w = (PAT_WORD[pat][k] & PAT_MASK[pat][k]) | ($urandom & ~PAT_MASK[pat][k]);
      if (corrupt && k == bad_word) w[bad_bit] = ~w[bad_bit];
      queue_word(w);
    end
  endtask

  task automatic random_segment();
    int    goal;
    int    pat;
    word_t w;
    segment_q.delete();
    stream_words = 0;
    goal = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 11);
    while (stream_words < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          w = $urandom;
          case ($urandom_range(0, 3))
            0: w[31:28] = 4'he;
            1: w = PAT_WORD[$urandom_range(0, N_PATTERNS - 1)][0];
            default: ;
          endcase
          queue_word(w);
        end
        4, 5, 6, 7: begin
          pat = $urandom_range(0, N_PATTERNS - 1);
          queue_pattern(pat, PAT_LEN[pat], 1'b0);
        end
        8: begin
          pat = $urandom_range(0, 11);
          queue_pattern(pat, $urandom_range(1, PAT_LEN[pat] - 1), 1'b0);
        end
        default: begin
          pat = $urandom_range(0, N_PATTERNS - 1);
          queue_pattern(pat, PAT_LEN[pat], 1'b1);
        end
      endcase
    end
    // Cut a pattern short at the segment end
    if ($urandom_range(0, 3) == 0) begin
      pat = $urandom_range(0, 11);
      queue_pattern(pat, PAT_LEN[pat] - 1, 1'b0);
    end
    segment_q[segment_q.size() - 1].seg_end = 1'b1;
    foreach (segment_q[i])
      send_request(segment_q[i].cmd, segment_q[i].word, segment_q[i].slot,
                   segment_q[i].seg_end);
  endtask

  // Receive side: check accepted words and stall on a shifting pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
      stall_mode <= STALL_NONE;
    end else begin
      if (out_valid && !out_stall) board.check_word(patched_word, last_word);
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_COMB:  out_stall <= (stall_tick[1:0] != 2'd0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles, %0d words still pending",
                 IDLE_LIMIT, board.expected_words.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    board         = new();
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_STREAM;
    code_word     = '0;
    target_index  = '0;
    segment_end   = 1'b0;
    requests_sent = 0;
    burst_left    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole target table before any code word
    for (int i = 0; i < TARGET_SLOTS; i++)
      send_request(CMD_LOAD, (i == 0) ? 32'h0 : (i == TARGET_SLOTS - 1) ? 32'hffffffff :
                   32'h8000_0000 + i * 32'h0001_1000, 4'(i), 1'b0);
    // Out-of-range slot is dropped, segment end ignored on a load
    send_request(CMD_LOAD, 32'hdeadbeef, 4'hf, 1'b1);
    send_request(CMD_STREAM, 32'hffffffff, 4'h0, 1'b1);
    // Jump to a zero target, then a nop that fails its condition and one that holds
    send_request(CMD_STREAM, 32'hef900005, 4'h0, 1'b0);
    send_request(CMD_STREAM, 32'he1a0f00e, 4'h0, 1'b0);
    send_request(CMD_STREAM, 32'hee073f5e, 4'h0, 1'b0);
    send_request(CMD_STREAM, 32'hee070f17, 4'h0, 1'b1);
    // Pattern cut off by the segment end
    send_request(CMD_STREAM, 32'hef900003, 4'h0, 1'b0);
    send_request(CMD_STREAM, 32'he3700a01, 4'h0, 1'b1);
    // Eight-word pattern fills the window before the segment ends
    for (int k = 0; k < WINDOW_WORDS; k++)
      send_request(CMD_STREAM, PAT_WORD[3][k], 4'h0, 1'b0);
    send_request(CMD_STREAM, 32'h0, 4'h0, 1'b1);

    while (requests_sent < RANDOM_STOP) random_segment();
    in_valid <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d segments from %0d requests (%0d table loads), %0d words checked",
             board.segments, requests_sent, board.loads, board.words_checked);
    $display("Rewrites seen: %0d jump, %0d push+jump, %0d nop; %0d mismatches",
             board.rewrites[REWRITE_JUMP], board.rewrites[REWRITE_PUSH_JUMP],
             board.rewrites[REWRITE_NOP], board.mismatches);
    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
